[design/unix_seconds_to_civil_date_core_macros.svh]
// Assertion macros used by the port-level checker.
`ifndef UNIX_SECONDS_TO_CIVIL_DATE_CORE_MACROS_SVH
`define UNIX_SECONDS_TO_CIVIL_DATE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define USCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define USCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/uscd_pkg.sv]
// Constants and helpers for the unix seconds to civil date converter.
package uscd_pkg;

	localparam int unsigned SEC_W   = 32;
	localparam int unsigned ZONE_W  = 5;
	localparam logic signed [ZONE_W-1:0] ZONE_RESET = 5'sd8;

	// floor(n/60) = (n * M60) >> 37 for any 32-bit n
	localparam logic [31:0] M60       = 32'h8888_8889;
	localparam int unsigned M60_SHIFT = 37;

	// floor(n/24) = (n * M24) >> 26 for n below 2^23
	localparam logic [21:0] M24       = 22'd2796203;
	localparam int unsigned M24_SHIFT = 26;

	// Julian-day civil date constants
	localparam logic [21:0] JDN_OFFSET = 22'd2472632;
	// 4a+3 thresholds for the 400-year cycle count (only 67..69 reachable)
	localparam logic [23:0] CYC68_MIN  = 24'd9934596;   // 146097*68
	localparam logic [23:0] CYC69_MIN  = 24'd10080693;  // 146097*69
	// floor(146097*b/4) for b = 67, 68, 69
	localparam logic [21:0] CYC67_BASE = 22'd2447124;
	localparam logic [21:0] CYC68_BASE = 22'd2483649;
	localparam logic [21:0] CYC69_BASE = 22'd2520173;

	// floor(n/1461) = (n * M1461) >> 30 for n below 2^18
	localparam logic [19:0] M1461       = 20'd734937;
	localparam int unsigned M1461_SHIFT = 30;
	localparam logic [10:0] DAYS_4Y     = 11'd1461;

	// floor(n/153) = (n * M153) >> 20 for n below 2^11
	localparam logic [12:0] M153       = 13'd6854;
	localparam int unsigned M153_SHIFT = 20;

	localparam logic [3:0] MON_WRAP  = 4'd10;
	localparam logic [6:0] YEARS_CENT = 7'd100;

	localparam logic [5:0] MAX_SEC  = 6'd59;
	localparam logic [4:0] MAX_HOUR = 5'd23;
	localparam logic [3:0] MAX_MON  = 4'd11;
	localparam logic [7:0] MIN_YEAR = 8'd70;
	localparam logic [7:0] MAX_YEAR = 8'd206;

	// Day offset of March-based month m: floor((153*m+2)/5)
	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

[design/unix_seconds_to_civil_date_core.sv]
// Unix seconds to local civil date, nine-stage pipeline.
//
// Input channel in_valid/in_ready carries unix_seconds; output channel
// out_valid/out_ready carries second, minute, hour, day, month and year.
// Both use valid/ready, a transfer happens when both are high.
// cfg_we writes the signed whole-hour zone offset from cfg_wdata; write it
// only while no item is in flight. Reset value of the offset is +8.
// Each item passes through stage registers S1 to S9, and out_valid is the S9
// valid bit. One item per cycle is sustained while out_ready is high: each
// stage holds one item and loads whenever it is empty or its successor
// loads, so transfers can follow back to back with no gaps.
// When out_ready is low, full stages hold; in_ready drops only once every
// stage holds a valid item, and no item is lost or repeated.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the
// offset reset value.
module unix_seconds_to_civil_date_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic signed [uscd_pkg::ZONE_W-1:0]     cfg_wdata,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic        [uscd_pkg::SEC_W-1:0]      unix_seconds,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic        [5:0]                      second_of_minute,
	output logic        [5:0]                      minute_of_hour,
	output logic        [4:0]                      hour_of_day,
	output logic        [4:0]                      day_of_month,
	output logic        [3:0]                      month_index,
	output logic        [7:0]                      years_since_1900
);

	logic signed [uscd_pkg::ZONE_W-1:0] zone_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic en1, en2, en3, en4, en5, en6, en7, en8, en9;

	// stage registers
	logic [26:0] mins_s1;
	logic [5:0]  slo_s1;
	logic [5:0]  sec_s2, sec_s3, sec_s4, sec_s5, sec_s6, sec_s7, sec_s8, sec_s9;
	logic [5:0]  mlo_s2;
	logic [20:0] hours_s2;
	logic [5:0]  min_s3, min_s4, min_s5, min_s6, min_s7, min_s8, min_s9;
	logic [20:0] local_s3;
	logic [15:0] days_s4;
	logic [4:0]  llo_s4;
	logic [4:0]  hour_s5, hour_s6, hour_s7, hour_s8, hour_s9;
	logic [15:0] c_s5, c_s6;
	logic [1:0]  cyc_s5, cyc_s6, cyc_s7, cyc_s8;
	logic [6:0]  d_s6, d_s7, d_s8;
	logic [8:0]  e_s7, e_s8;
	logic [3:0]  m_s8;
	logic [4:0]  mday_s9;
	logic [3:0]  mon_s9;
	logic [7:0]  year_s9;

	// combinational stage results
	logic [63:0]        prod1;
	logic [58:0]        prod2;
	logic [5:0]         sec_c;
	logic [5:0]         min_c;
	logic signed [21:0] hsum;
	logic [20:0]        local_c;
	logic [42:0]        prod4;
	logic [4:0]         hour_c;
	logic [21:0]        a_c;
	logic [23:0]        a4_c;
	logic [1:0]         cyc_c;
	logic [21:0]        c_c;
	logic [37:0]        prod6;
	logic [17:0]        d1461_c;
	logic [8:0]         e_c;
	logic [10:0]        n8_c;
	logic [23:0]        prod8;
	logic               wrap_c;
	logic [8:0]         mday_c;
	logic [8:0]         year_c;

	// stage advance: a stage loads when it is empty or its successor loads
	assign en9      = !v_s9 || out_ready;
	assign en8      = !v_s8 || en9;
	assign en7      = !v_s7 || en8;
	assign en6      = !v_s6 || en7;
	assign en5      = !v_s5 || en6;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= uscd_pkg::ZONE_RESET;
		end else if (cfg_we) begin
			zone_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
			if (en8) v_s8 <= v_s7;
			if (en9) v_s9 <= v_s8;
		end
	end

	// S1: minutes = seconds / 60
	assign prod1 = 64'(unix_seconds) * 64'(uscd_pkg::M60);

	// S2: seconds field, hours = minutes / 60
	assign sec_c = slo_s1 - 6'(mins_s1[5:0] * 6'd60);
	assign prod2 = 59'(mins_s1) * 59'(uscd_pkg::M60);

	// S3: minutes field, local hours with zone offset, clamped at the epoch
	assign min_c   = mlo_s2 - 6'(hours_s2[5:0] * 6'd60);
	assign hsum    = $signed({1'b0, hours_s2}) + 22'(zone_q);
	assign local_c = hsum[21] ? '0 : hsum[20:0];

	// S4: days = local hours / 24
	assign prod4 = 43'(local_s3) * 43'(uscd_pkg::M24);

	// S5: hour field, 400-year cycle select and day within cycle
	assign hour_c = llo_s4 - 5'(days_s4[4:0] * 5'd24);
	assign a_c    = 22'(days_s4) + uscd_pkg::JDN_OFFSET;
	assign a4_c   = {a_c, 2'b11};
	always_comb begin
		if (a4_c >= uscd_pkg::CYC69_MIN) begin
			cyc_c = 2'd2;
			c_c   = a_c - uscd_pkg::CYC69_BASE;
		end else if (a4_c >= uscd_pkg::CYC68_MIN) begin
			cyc_c = 2'd1;
			c_c   = a_c - uscd_pkg::CYC68_BASE;
		end else begin
			cyc_c = 2'd0;
			c_c   = a_c - uscd_pkg::CYC67_BASE;
		end
	end

	// S6: years within cycle d = (4c+3) / 1461
	assign prod6 = 38'({c_s5, 2'b11}) * 38'(uscd_pkg::M1461);

	// S7: day of year e = c - 1461*d/4
	assign d1461_c = 18'(d_s6) * 18'(uscd_pkg::DAYS_4Y);
	assign e_c     = 9'(c_s6 - 16'(d1461_c >> 2));

	// S8: March-based month m = (5e+2) / 153
	assign n8_c  = 11'(e_s7) * 11'd5 + 11'd2;
	assign prod8 = 24'(n8_c) * 24'(uscd_pkg::M153);

	// S9: day, month and year fields
	assign wrap_c = (m_s8 >= uscd_pkg::MON_WRAP);
	assign mday_c = e_s8 - uscd_pkg::month_start(m_s8) + 9'd1;
	assign year_c = 9'(cyc_s8) * 9'(uscd_pkg::YEARS_CENT) + 9'(d_s8) + 9'(wrap_c);

	always_ff @(posedge clk) begin
		if (en1) begin
			mins_s1 <= prod1[63:37];
			slo_s1  <= unix_seconds[5:0];
		end
		if (en2) begin
			sec_s2   <= sec_c;
			mlo_s2   <= mins_s1[5:0];
			hours_s2 <= prod2[57:37];
		end
		if (en3) begin
			sec_s3   <= sec_s2;
			min_s3   <= min_c;
			local_s3 <= local_c;
		end
		if (en4) begin
			sec_s4  <= sec_s3;
			min_s4  <= min_s3;
			days_s4 <= prod4[41:26];
			llo_s4  <= local_s3[4:0];
		end
		if (en5) begin
			sec_s5  <= sec_s4;
			min_s5  <= min_s4;
			hour_s5 <= hour_c;
			c_s5    <= c_c[15:0];
			cyc_s5  <= cyc_c;
		end
		if (en6) begin
			sec_s6  <= sec_s5;
			min_s6  <= min_s5;
			hour_s6 <= hour_s5;
			c_s6    <= c_s5;
			cyc_s6  <= cyc_s5;
			d_s6    <= prod6[36:30];
		end
		if (en7) begin
			sec_s7  <= sec_s6;
			min_s7  <= min_s6;
			hour_s7 <= hour_s6;
			cyc_s7  <= cyc_s6;
			d_s7    <= d_s6;
			e_s7    <= e_c;
		end
		if (en8) begin
			sec_s8  <= sec_s7;
			min_s8  <= min_s7;
			hour_s8 <= hour_s7;
			cyc_s8  <= cyc_s7;
			d_s8    <= d_s7;
			e_s8    <= e_s7;
			m_s8    <= prod8[23:20];
		end
		if (en9) begin
			sec_s9  <= sec_s8;
			min_s9  <= min_s8;
			hour_s9 <= hour_s8;
			mday_s9 <= mday_c[4:0];
			mon_s9  <= wrap_c ? (m_s8 - uscd_pkg::MON_WRAP) : (m_s8 + 4'd2);
			year_s9 <= year_c[7:0];
		end
	end

	assign out_valid        = v_s9;
	assign second_of_minute = sec_s9;
	assign minute_of_hour   = min_s9;
	assign hour_of_day      = hour_s9;
	assign day_of_month     = mday_s9;
	assign month_index      = mon_s9;
	assign years_since_1900 = year_s9;

endmodule

[design/uscd_checker.sv]
// Port-level checker for the civil date converter, bound to the top level.
`include "unix_seconds_to_civil_date_core_macros.svh"

module uscd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [5:0]  second_of_minute,
	input logic [5:0]  minute_of_hour,
	input logic [4:0]  hour_of_day,
	input logic [4:0]  day_of_month,
	input logic [3:0]  month_index,
	input logic [7:0]  years_since_1900
);

	logic [33:0] fields;
	logic        stalled;
	logic        time_ok;
	logic        date_ok;

	assign fields  = {second_of_minute, minute_of_hour, hour_of_day,
		day_of_month, month_index, years_since_1900};
	assign stalled = out_valid && !out_ready;
	assign time_ok = (second_of_minute <= uscd_pkg::MAX_SEC)
		&& (minute_of_hour <= uscd_pkg::MAX_SEC)
		&& (hour_of_day <= uscd_pkg::MAX_HOUR);
	assign date_ok = (day_of_month != 5'd0)
		&& (month_index <= uscd_pkg::MAX_MON)
		&& (years_since_1900 >= uscd_pkg::MIN_YEAR)
		&& (years_since_1900 <= uscd_pkg::MAX_YEAR);

	// a stalled result keeps its fields
	`USCD_ASSERT_NXT(a_out_hold, clk, arst_n, stalled, out_valid && $stable(fields), "result moved")

	// with the receiver ready the pipeline never backs up
	`USCD_ASSERT_IMP(a_no_backup, clk, arst_n, out_ready, in_ready, "in_ready low, out_ready high")

	// time of day fields stay in range
	`USCD_ASSERT_IMP(a_time_range, clk, arst_n, out_valid, time_ok, "time field out of range")

	// date fields stay in range
	`USCD_ASSERT_IMP(a_date_range, clk, arst_n, out_valid, date_ok, "date field out of range")

endmodule

bind unix_seconds_to_civil_date_core uscd_checker u_uscd_checker (.*);

[test/unix_seconds_to_civil_date_core_tb.sv]
// Testbench for the unix seconds to local civil date converter.
module unix_seconds_to_civil_date_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIPE_LATENCY = 9;
	localparam int RANDOM_PER_PHASE = 140;

	localparam longint unsigned JDN_SHIFT  = 2472632;
	localparam longint unsigned DAYS_400Y  = 146097;
	localparam longint unsigned DAYS_4Y    = 1461;
	localparam longint unsigned MONTH_SPAN = 153;
	localparam longint unsigned YEAR_BIAS  = 6700;

	typedef struct packed {
		logic [5:0] second_of_minute;
		logic [5:0] minute_of_hour;
		logic [4:0] hour_of_day;
		logic [4:0] day_of_month;
		logic [3:0] month_index;
		logic [7:0] years_since_1900;
	} civil_time_t;

	class civil_date_scoreboard_t;
		civil_time_t awaited[$];
		logic signed [uscd_pkg::ZONE_W-1:0] zone = uscd_pkg::ZONE_RESET;
		int errors = 0;
		int matched = 0;

		function civil_time_t to_local_civil(logic [31:0] s);
			longint unsigned mins, days, a, b, c, d, e, m;
			longint hrs;
			civil_time_t r;
			mins = longint'(s) / 60;
			r.second_of_minute = 6'(longint'(s) % 60);
			r.minute_of_hour = 6'(mins % 60);
			hrs = longint'(mins / 60) + longint'(zone);
			// local time before the epoch clamps to hour zero
			if (hrs < 0)
				hrs = 0;
			r.hour_of_day = 5'(hrs % 24);
			days = hrs / 24;
			a = days + JDN_SHIFT;
			b = (4 * a + 3) / DAYS_400Y;
			c = a - (DAYS_400Y * b) / 4;
			d = (4 * c + 3) / DAYS_4Y;
			e = c - (DAYS_4Y * d) / 4;
			m = (5 * e + 2) / MONTH_SPAN;
			r.day_of_month = 5'(e - (MONTH_SPAN * m + 2) / 5 + 1);
			r.month_index = 4'(m + 2 - 12 * (m / 10));
			r.years_since_1900 = 8'(100 * b + d + m / 10 - YEAR_BIAS);
			return r;
		endfunction

		function void note_input(logic [31:0] s);
			awaited = {awaited, to_local_civil(s)};
		endfunction

		function void check_result(civil_time_t got);
			civil_time_t want;
			if (awaited.size() == 0) begin
				$error("result with no pending timestamp");
				errors++;
				return;
			end
			want = awaited.pop_front();
			matched++;
			if (got.second_of_minute !== want.second_of_minute) begin
				$error("second_of_minute: expected %0d, got %0d",
					want.second_of_minute, got.second_of_minute);
				errors++;
			end
			if (got.minute_of_hour !== want.minute_of_hour) begin
				$error("minute_of_hour: expected %0d, got %0d",
					want.minute_of_hour, got.minute_of_hour);
				errors++;
			end
			if (got.hour_of_day !== want.hour_of_day) begin
				$error("hour_of_day: expected %0d, got %0d",
					want.hour_of_day, got.hour_of_day);
				errors++;
			end
			if (got.day_of_month !== want.day_of_month) begin
				$error("day_of_month: expected %0d, got %0d",
					want.day_of_month, got.day_of_month);
				errors++;
			end
			if (got.month_index !== want.month_index) begin
				$error("month_index: expected %0d, got %0d",
					want.month_index, got.month_index);
				errors++;
			end
			if (got.years_since_1900 !== want.years_since_1900) begin
				$error("years_since_1900: expected %0d, got %0d",
					want.years_since_1900, got.years_since_1900);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic signed [uscd_pkg::ZONE_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	logic [uscd_pkg::SEC_W-1:0] unix_seconds;
	logic out_valid;
	logic out_ready;
	logic [5:0] second_of_minute;
	logic [5:0] minute_of_hour;
	logic [4:0] hour_of_day;
	logic [4:0] day_of_month;
	logic [3:0] month_index;
	logic [7:0] years_since_1900;

	civil_date_scoreboard_t sb;
	bit steady;
	int phases_run;

	unix_seconds_to_civil_date_core i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.unix_seconds     (unix_seconds),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.second_of_minute (second_of_minute),
		.minute_of_hour   (minute_of_hour),
		.hour_of_day      (hour_of_day),
		.day_of_month     (day_of_month),
		.month_index      (month_index),
		.years_since_1900 (years_since_1900)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("timeout waiting for converter results");
		$display("== FAIL ==");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Receiver backpressure: stall bursts chosen at the falling edge.
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ready = 1'b0;
			end else begin
				stall_left = pick_gap();
				out_ready = (stall_left == 0);
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check_result('{second_of_minute, minute_of_hour, hour_of_day,
					day_of_month, month_index, years_since_1900});
		end
	end

	// Valid stays up across back-to-back transfers; it only drops for a gap.
	task automatic send_stamp(logic [31:0] s);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		unix_seconds = s;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_input(s);
	endtask

	task automatic drain_pipeline();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_zone(logic signed [uscd_pkg::ZONE_W-1:0] v);
		drain_pipeline();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.zone = v;
	endtask

	function automatic logic [31:0] rand_stamp();
		longint t;
		case ($urandom_range(0, 9)) inside
			6: return $urandom_range(0, 200000);
			7: return 32'hFFFF_FFFF - $urandom_range(0, 200000);
			8, 9: begin
				// around local midnight
				t = longint'($urandom_range(1, 49709)) * 86400
					- longint'(sb.zone) * 3600 + $urandom_range(0, 7200) - 3600;
				if (t < 0 || t > 64'hFFFF_FFFF)
					return $urandom;
				return t[31:0];
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic run_phase(int zone_v, int count, bit pause_midway);
		int b;
		send_stamp(32'd0);
		send_stamp(32'hFFFF_FFFF);
		if (zone_v < 0) begin
			// the hour just before and at the saturation edge
			b = -zone_v * 3600;
			send_stamp(b - 1);
			send_stamp(b);
			send_stamp(b - 3600);
		end
		for (int i = 0; i < count; i++) begin
			if (pause_midway && i == count / 2)
				drain_pipeline();
			send_stamp(rand_stamp());
		end
		phases_run++;
	endtask

	initial begin
		logic [31:0] directed[] = '{
			32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
			32'd946684799, 32'd951782400, 32'd951868800, 32'd1234567890,
			32'd2147483647, 32'd2147483648, 32'h5555_5555, 32'hAAAA_AAAA,
			32'd4107542399, 32'd4107542400, 32'hFFFF_FFFF
		};
		int zone_plan[] = '{-12, 14, -16, 15, 0, 0, 0, 0, 0};
		sb = new;
		steady = 1'b0;
		phases_run = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		unix_seconds = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed stamps first, then a random phase, both at the reset offset
		foreach (directed[i])
			send_stamp(directed[i]);
		run_phase(int'(uscd_pkg::ZONE_RESET), RANDOM_PER_PHASE, 1'b1);

		for (int p = 5; p < zone_plan.size(); p++)
			zone_plan[p] = int'($signed(5'($urandom_range(0, 31))));
		foreach (zone_plan[p]) begin
			write_zone(5'(zone_plan[p]));
			steady = (p == 1 || p == 4);
			run_phase(zone_plan[p], RANDOM_PER_PHASE, p == 6);
		end
		steady = 1'b0;
		drain_pipeline();

		$display("Converted %0d timestamps across %0d zone offsets, from the epoch",
			sb.matched, phases_run);
		$display("with pre-epoch clamping up to the 2106 end of the input range.");
		if (sb.errors == 0 && sb.awaited.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

[unix_seconds_to_civil_date_core.f]
+incdir+design
design/uscd_pkg.sv
design/unix_seconds_to_civil_date_core.sv
design/uscd_checker.sv
test/unix_seconds_to_civil_date_core_tb.sv
